// ----- sv/tksi_pkg.sv -----
// package for the top-k sorted insert block: sizes, request codes and the
// entry and cell control types; no dependencies
`default_nettype none

package tksi_pkg;

   // number of ranks held in the cell row
   localparam int DEPTH = 8;
   // index into the row and count of held entries
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // field widths of the request and result ports
   localparam int CMD_W   = 2;
   localparam int SCORE_W = 32;
   localparam int POS_W   = 16;
   localparam int SLOT_W  = 3;
   localparam int FILL_W  = 4;

   // request codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // one stored entry
   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
   } entry_type;

   // what every cell of the row does this cycle
   typedef struct packed {
      logic insert;
      logic rotate;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- sv/tksi_cell.sv -----
// one rank of the sorted row: holds an entry, compares it with the new
// request and shifts or rotates with its neighbours; uses tksi_pkg
`default_nettype none

module tksi_cell (
   input  wire                   clock,
   input  tksi_pkg::cell_ctl_type ctl,
   input  tksi_pkg::entry_type   new_entry,
   input  wire                   occ,
   input  wire                   prev_keep,
   input  tksi_pkg::entry_type   prev_entry,
   input  wire                   next_occ,
   input  tksi_pkg::entry_type   next_entry,
   input  tksi_pkg::entry_type   head_entry,
   output logic                  keep,
   output tksi_pkg::entry_type   entry
);
   import tksi_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // held entry stays ahead of the new one when its score is greater or equal
   assign keep  = occ && (entry_ff.score >= new_entry.score);
   assign entry = entry_ff;

   // insert: hold, take the new entry, or shift down from the rank above
   // rotate: take the next rank, the head entry wraps to the last held rank
   always_comb begin
      entry_in = entry_ff;
      priority if (ctl.insert) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in = new_entry;
         end else begin
            entry_in = prev_entry;
         end
      end else if (ctl.rotate) begin
         if (next_occ) begin
            entry_in = next_entry;
         end else begin
            entry_in = head_entry;
         end
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ----- sv/top_k_sorted_insert_core.sv -----
// top level of the top-k sorted insert block: request decode, fill count,
// dump sequencing, result register and the row of tksi_cell; uses tksi_pkg
`default_nettype none

// Keeps the best DEPTH entries (signed Q16.16 score with x,y) in descending
// score order, one rank per cell; equal scores keep arrival order.
// Request channel: a request is taken at a rising edge with start high and
// busy low. req_cmd selects insert, dump or clear; code 3 is ignored.
// Result channel: each result sits on the rsp_ ports for one cycle, flagged
// by rsp_valid; rsp_last marks the final result of a request. The receiver
// cannot stall, so results are never held back.
// Insert: every cell compares and shifts in parallel; the
// result appears the cycle after the request and busy stays low, so one
// insert per cycle is sustained. An insert that does not beat the lowest
// entry of a full row is dropped and echoed with rsp_accepted low.
// Dump: the row rotates one rank per cycle through the head cell, giving
// n results on consecutive cycles (n = entries held, one result when
// empty); busy is high until the last result; the row is back in order.
// Clear: one result, fill drops to zero in the same cycle.
// Reset empties the row and idles the dump sequencer; no clearing pass.
module top_k_sorted_insert_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [tksi_pkg::CMD_W-1:0]       req_cmd,
   input  wire  signed [tksi_pkg::SCORE_W-1:0] req_score,
   input  wire  signed [tksi_pkg::POS_W-1:0]   req_pos_x,
   input  wire  signed [tksi_pkg::POS_W-1:0]   req_pos_y,
   output logic                             rsp_valid,
   output logic signed [tksi_pkg::SCORE_W-1:0] rsp_out_score,
   output logic signed [tksi_pkg::POS_W-1:0]   rsp_out_x,
   output logic signed [tksi_pkg::POS_W-1:0]   rsp_out_y,
   output logic [tksi_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [tksi_pkg::FILL_W-1:0]      rsp_fill,
   output logic                             rsp_accepted,
   output logic                             rsp_entry_valid,
   output logic                             rsp_last
);
   import tksi_pkg::*;

   // control state
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             dump_active_ff, dump_active_in;
   logic [IDX_W-1:0] dump_idx_ff, dump_idx_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   entry_type        rsp_entry_ff, rsp_entry_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [FILL_W-1:0] rsp_fill_ff, rsp_fill_in;
   logic             rsp_acc_ff, rsp_acc_in;
   logic             rsp_ev_ff, rsp_ev_in;
   logic             rsp_last_ff, rsp_last_in;

   // row signals
   entry_type        new_entry;
   entry_type        cell_entry [DEPTH];
   logic [DEPTH-1:0] keep;
   logic [DEPTH-1:0] occ;
   cell_ctl_type     ctl;
   logic             take;
   logic [CNT_W-1:0] ins_pos;
   logic             drop;

   assign busy = dump_active_ff;
   assign take = start && !dump_active_ff;

   assign new_entry.score = req_score;
   assign new_entry.pos_x = req_pos_x;
   assign new_entry.pos_y = req_pos_y;

   // occupancy of each rank from the fill count
   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_row
         assign occ[g] = fill_ff > CNT_W'(g);

         if (g == 0) begin : g_head
            tksi_cell u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .new_entry  (new_entry),
               .occ        (occ[g]),
               .prev_keep  (1'b1),
               .prev_entry (new_entry),
               .next_occ   ((DEPTH > 1) ? occ[(g + 1) % DEPTH] : 1'b0),
               .next_entry (cell_entry[(g + 1) % DEPTH]),
               .head_entry (cell_entry[0]),
               .keep       (keep[g]),
               .entry      (cell_entry[g])
            );
         end else if (g == DEPTH - 1) begin : g_tail
            tksi_cell u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .new_entry  (new_entry),
               .occ        (occ[g]),
               .prev_keep  (keep[g - 1]),
               .prev_entry (cell_entry[g - 1]),
               .next_occ   (1'b0),
               .next_entry (cell_entry[0]),
               .head_entry (cell_entry[0]),
               .keep       (keep[g]),
               .entry      (cell_entry[g])
            );
         end else begin : g_mid
            tksi_cell u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .new_entry  (new_entry),
               .occ        (occ[g]),
               .prev_keep  (keep[g - 1]),
               .prev_entry (cell_entry[g - 1]),
               .next_occ   (occ[g + 1]),
               .next_entry (cell_entry[g + 1]),
               .head_entry (cell_entry[0]),
               .keep       (keep[g]),
               .entry      (cell_entry[g])
            );
         end
      end
   endgenerate

   // insertion rank: first cell that does not keep its entry ahead
   always_comb begin
      ins_pos = CNT_W'(DEPTH);
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!keep[i]) begin
            ins_pos = CNT_W'(i);
         end
      end
   end

   // full row and the new score does not beat the lowest
   assign drop = (ins_pos == CNT_W'(DEPTH));

   // request decode, dump sequencing and result formation
   always_comb begin
      fill_in        = fill_ff;
      dump_active_in = dump_active_ff;
      dump_idx_in    = dump_idx_ff;
      ctl            = '0;
      rsp_valid_in   = 1'b0;
      rsp_entry_in   = '0;
      rsp_slot_in    = '0;
      rsp_fill_in    = FILL_W'(fill_ff);
      rsp_acc_in     = 1'b0;
      rsp_ev_in      = 1'b0;
      rsp_last_in    = 1'b1;

      if (dump_active_ff) begin
         // next rank of a dump in progress
         ctl.rotate   = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_entry_in = cell_entry[0];
         rsp_slot_in  = SLOT_W'(dump_idx_ff);
         rsp_ev_in    = 1'b1;
         rsp_last_in  = (CNT_W'(dump_idx_ff) + CNT_W'(1)) == fill_ff;
         dump_idx_in  = dump_idx_ff + IDX_W'(1);
         if (rsp_last_in) begin
            dump_active_in = 1'b0;
         end
      end else if (take) begin
         unique case (req_cmd)
            CMD_INSERT: begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = new_entry;
               if (!drop) begin
                  ctl.insert  = 1'b1;
                  fill_in     = (fill_ff == CNT_W'(DEPTH)) ? fill_ff
                                                           : fill_ff + CNT_W'(1);
                  rsp_slot_in = SLOT_W'(ins_pos);
                  rsp_fill_in = FILL_W'(fill_in);
                  rsp_acc_in  = 1'b1;
               end
            end
            CMD_DUMP: begin
               rsp_valid_in = 1'b1;
               if (fill_ff != '0) begin
                  ctl.rotate     = 1'b1;
                  rsp_entry_in   = cell_entry[0];
                  rsp_ev_in      = 1'b1;
                  rsp_last_in    = (fill_ff == CNT_W'(1));
                  dump_active_in = !rsp_last_in;
                  dump_idx_in    = IDX_W'(1);
               end
            end
            CMD_CLEAR: begin
               rsp_valid_in = 1'b1;
               fill_in      = '0;
               rsp_fill_in  = '0;
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff        <= '0;
         dump_active_ff <= 1'b0;
         dump_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fill_ff        <= fill_in;
         dump_active_ff <= dump_active_in;
         dump_idx_ff    <= dump_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_entry_ff <= rsp_entry_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_score   = rsp_entry_ff.score;
   assign rsp_out_x       = rsp_entry_ff.pos_x;
   assign rsp_out_y       = rsp_entry_ff.pos_y;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_fill        = rsp_fill_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_entry_valid = rsp_ev_ff;
   assign rsp_last        = rsp_last_ff;

   // a dump in progress always has a further held rank to stream
   a_dump_in_range: assert property (@(posedge clock) disable iff (reset)
      dump_active_ff |-> (CNT_W'(dump_idx_ff) < fill_ff) && (dump_idx_ff != '0))
      else $error("dump index outside the held ranks");

   // fill never goes past the row length
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond row length");

   // a placed insert leaves at least one entry held
   a_insert_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_acc_ff |-> (rsp_fill_ff != '0) && rsp_last_ff)
      else $error("placed insert with empty row");

   // the last result of a dump ends the busy phase
   a_dump_ends: assert property (@(posedge clock) disable iff (reset)
      dump_active_ff && rsp_last_in |=> !dump_active_ff)
      else $error("dump still busy after its last result");

   // every taken request with a known code gives a result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      take && ((req_cmd == CMD_INSERT) || (req_cmd == CMD_DUMP) ||
               (req_cmd == CMD_CLEAR)) |=> rsp_valid_ff)
      else $error("request without result");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// testbench for top_k_sorted_insert_core: directed request table then random requests,
// each result checked against a ranked-list predictor kept here
// depends on tksi_pkg and top_k_sorted_insert_core
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tksi_pkg::*;

   // code 3 is left unused by the block
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7fffffff;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh80000000;
   localparam int RANDOM_REQUESTS = 100;
   localparam int STALL_LIMIT = 500;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic [SLOT_W-1:0]         slot;
      logic [FILL_W-1:0]         fill;
      logic                      accepted;
      logic                      entry_valid;
      logic                      last;
   } rank_result_type;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic signed [SCORE_W-1:0] score;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic                      typed;
      rank_result_type           result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [CMD_W-1:0] req_cmd;
   logic signed [SCORE_W-1:0] req_score;
   logic signed [POS_W-1:0] req_pos_x;
   logic signed [POS_W-1:0] req_pos_y;
   logic rsp_valid;
   logic signed [SCORE_W-1:0] rsp_out_score;
   logic signed [POS_W-1:0] rsp_out_x;
   logic signed [POS_W-1:0] rsp_out_y;
   logic [SLOT_W-1:0] rsp_slot;
   logic [FILL_W-1:0] rsp_fill;
   logic rsp_accepted;
   logic rsp_entry_valid;
   logic rsp_last;

   // typed expectation travelling with the request on the port
   logic row_typed;
   rank_result_type row_result;

   // predictor state: the ranked list and its fill
   entry_type ranked_entries [DEPTH];
   int unsigned ranked_fill;
   rank_result_type pending_results [$];
   int error_count = 0;
   int stall_cycles;

   // directed stimulus table
   stim_row_type directed_rows [$];

   top_k_sorted_insert_core dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_score(req_score),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .rsp_valid(rsp_valid),
      .rsp_out_score(rsp_out_score),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_slot(rsp_slot),
      .rsp_fill(rsp_fill),
      .rsp_accepted(rsp_accepted),
      .rsp_entry_valid(rsp_entry_valid),
      .rsp_last(rsp_last)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // append one expected result to the outstanding queue
   function automatic void expect_result(input rank_result_type res);
      pending_results.insert(pending_results.size(), res);
   endfunction

   // append one row to the directed table
   function automatic void add_row(input stim_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // work out the results of one request and update the ranked list
   function automatic void rank_request(input logic [CMD_W-1:0] cmd,
                                        input logic signed [SCORE_W-1:0] score,
                                        input logic signed [POS_W-1:0] pos_x,
                                        input logic signed [POS_W-1:0] pos_y,
                                        input bit record);
      rank_result_type res;
      int unsigned p;
      int unsigned new_fill;
      logic signed [SCORE_W-1:0] held_score;
      res = '0;
      res.last = 1'b1;
      case (cmd)
         CMD_INSERT: begin
            p = ranked_fill;
            res.score = score;
            res.pos_x = pos_x;
            res.pos_y = pos_y;
            if (p >= DEPTH) begin
               held_score = ranked_entries[DEPTH-1].score;
               if (held_score < score) begin
                  p = DEPTH - 1;
               end else begin
                  // full list and no strict win: dropped, input echoed
                  res.fill = FILL_W'(ranked_fill);
                  if (record) expect_result(res);
                  return;
               end
            end
            new_fill = p + 1;
            // walk up past every entry with a lower score; ties stay ahead
            while (p > 0) begin
               held_score = ranked_entries[p-1].score;
               if (!(held_score < score)) break;
               ranked_entries[p] = ranked_entries[p-1];
               p--;
            end
            ranked_entries[p] = '{score: score, pos_x: pos_x, pos_y: pos_y};
            ranked_fill = new_fill;
            res.slot = SLOT_W'(p);
            res.fill = FILL_W'(ranked_fill);
            res.accepted = 1'b1;
            if (record) expect_result(res);
         end
         CMD_DUMP: begin
            res.fill = FILL_W'(ranked_fill);
            if (ranked_fill == 0) begin
               if (record) expect_result(res);
            end else begin
               for (int i = 0; i < ranked_fill; i++) begin
                  res.score = ranked_entries[i].score;
                  res.pos_x = ranked_entries[i].pos_x;
                  res.pos_y = ranked_entries[i].pos_y;
                  res.slot = SLOT_W'(i);
                  res.entry_valid = 1'b1;
                  res.last = (i + 1 == ranked_fill);
                  if (record) expect_result(res);
               end
            end
         end
         CMD_CLEAR: begin
            ranked_fill = 0;
            if (record) expect_result(res);
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // result checking, request capture and stall watchdog
   always @(posedge clock) begin
      rank_result_type want;
      if (reset) begin
         ranked_fill = 0;
         stall_cycles = 0;
      end else begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("result with no request outstanding: score 0x%0h slot %0d",
                      rsp_out_score, rsp_slot);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               compare_field("out_score", want.score, rsp_out_score);
               compare_field("out_x", want.pos_x, rsp_out_x);
               compare_field("out_y", want.pos_y, rsp_out_y);
               compare_field("slot", want.slot, rsp_slot);
               compare_field("fill", want.fill, rsp_fill);
               compare_field("accepted", want.accepted, rsp_accepted);
               compare_field("entry_valid", want.entry_valid, rsp_entry_valid);
               compare_field("last", want.last, rsp_last);
            end
         end
         if (start && !busy) begin
            rank_request(req_cmd, req_score, req_pos_x, req_pos_y, !row_typed);
            if (row_typed) expect_result(row_result);
         end
         // nothing moving on either side
         if ((start && !busy) || rsp_valid) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // present one request and hold it until taken
   task automatic issue_request(input stim_row_type r);
      req_cmd = r.cmd;
      req_score = r.score;
      req_pos_x = r.pos_x;
      req_pos_y = r.pos_y;
      row_typed = r.typed;
      row_result = r.result;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // sender gap: mostly none, some short, a few long
   task automatic sender_gap(input bit no_idle);
      int pick;
      int cycles;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 60) cycles = 0;
      else if (pick < 90) cycles = $urandom_range(1, 3);
      else cycles = $urandom_range(8, 30);
      if (cycles > 0) begin
         start = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // hold off until every outstanding result has come back
   task automatic wait_drained();
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [SCORE_W-1:0] random_score();
      case ($urandom_range(0, 9))
         0: return SCORE_MIN;
         1: return SCORE_MAX;
         2: return 32'sd0;
         3: return -32'sd1;
         4, 5: return $signed(32'($urandom_range(0, 6)) << 14) - 32'sd49152;
         default: return $signed(32'($urandom));
      endcase
   endfunction

   initial begin
      stim_row_type r;
      int pick;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_INSERT;
      req_score = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      row_typed = 1'b0;
      row_result = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table; typed results where they are plain to see
      add_row('{CMD_DUMP, 32'sd0, 16'sd0, 16'sd0, 1'b1,
                '{32'sd0, 16'sd0, 16'sd0, 3'd0, 4'd0, 1'b0, 1'b0, 1'b1}});
      add_row('{CMD_UNUSED, -32'sd1, -16'sd1, -16'sd1, 1'b0, '0});
      add_row('{CMD_INSERT, SCORE_MAX, 16'sh7fff, 16'sh8000, 1'b1,
                '{SCORE_MAX, 16'sh7fff, 16'sh8000, 3'd0, 4'd1, 1'b1, 1'b0,
                  1'b1}});
      add_row('{CMD_INSERT, SCORE_MIN, 16'sh8000, 16'sh7fff, 1'b1,
                '{SCORE_MIN, 16'sh8000, 16'sh7fff, 3'd1, 4'd2, 1'b1, 1'b0,
                  1'b1}});
      // ties on zero keep arrival order
      add_row('{CMD_INSERT, 32'sd0, 16'sd1, 16'sd1, 1'b0, '0});
      add_row('{CMD_INSERT, 32'sd0, 16'sd2, 16'sd2, 1'b0, '0});
      add_row('{CMD_INSERT, 32'sh00010000, 16'sd3, 16'sd3, 1'b0, '0});
      add_row('{CMD_INSERT, -32'sh8000, 16'sd4, 16'sd4, 1'b0, '0});
      add_row('{CMD_INSERT, SCORE_MAX, 16'sd5, 16'sd5, 1'b0, '0});
      add_row('{CMD_INSERT, 32'sh00018000, 16'sd6, 16'sd6, 1'b0, '0});
      add_row('{CMD_DUMP, 32'sd0, 16'sd0, 16'sd0, 1'b0, '0});
      // full list, lowest is the minimum: a tie with it is dropped
      add_row('{CMD_INSERT, SCORE_MIN, 16'sd7, 16'sd7, 1'b1,
                '{SCORE_MIN, 16'sd7, 16'sd7, 3'd0, 4'd8, 1'b0, 1'b0, 1'b1}});
      add_row('{CMD_INSERT, 32'sh12345678, 16'sd8, 16'sd8, 1'b0, '0});
      add_row('{CMD_INSERT, -32'sh8000, 16'sd9, 16'sd9, 1'b0, '0});
      add_row('{CMD_INSERT, -32'sh7fff, 16'sd10, 16'sd10, 1'b0, '0});
      add_row('{CMD_UNUSED, 32'sd0, 16'sd0, 16'sd0, 1'b0, '0});
      add_row('{CMD_DUMP, 32'sd0, 16'sd0, 16'sd0, 1'b0, '0});
      add_row('{CMD_CLEAR, 32'sd0, 16'sd0, 16'sd0, 1'b1,
                '{32'sd0, 16'sd0, 16'sd0, 3'd0, 4'd0, 1'b0, 1'b0, 1'b1}});
      add_row('{CMD_DUMP, 32'sd0, 16'sd0, 16'sd0, 1'b1,
                '{32'sd0, 16'sd0, 16'sd0, 3'd0, 4'd0, 1'b0, 1'b0, 1'b1}});
      add_row('{CMD_INSERT, -32'sd1, -16'sd1, -16'sd1, 1'b1,
                '{-32'sd1, -16'sd1, -16'sd1, 3'd0, 4'd1, 1'b1, 1'b0, 1'b1}});
      add_row('{CMD_DUMP, 32'sd0, 16'sd0, 16'sd0, 1'b0, '0});
      add_row('{CMD_CLEAR, 32'sd0, 16'sd0, 16'sd0, 1'b1,
                '{32'sd0, 16'sd0, 16'sd0, 3'd0, 4'd0, 1'b0, 1'b0, 1'b1}});

      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i]);
         sender_gap(1'b0);
      end
      wait_drained();

      // random requests, insert heavy so the list fills and drops occur
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) r.cmd = CMD_INSERT;
         else if (pick < 85) r.cmd = CMD_DUMP;
         else if (pick < 93) r.cmd = CMD_CLEAR;
         else r.cmd = CMD_UNUSED;
         r.score = random_score();
         r.pos_x = 16'($urandom);
         r.pos_y = 16'($urandom);
         r.typed = 1'b0;
         r.result = '0;
         issue_request(r);
         if (n == RANDOM_REQUESTS / 2) wait_drained();
         // back-to-back stretch
         sender_gap(n >= 20 && n < 40);
      end
      start = 1'b0;

      // let the last results through, then a margin for stray ones
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- top_k_sorted_insert_core.f -----
sv/tksi_pkg.sv
sv/tksi_cell.sv
sv/top_k_sorted_insert_core.sv
test/testbench.sv
